// ===== rtl/mtte_pkg.sv =====
// Package: shared types, key codes and the character table of the multi-tap text entry block.
`timescale 1ns / 1ps
`default_nettype none

package mtte_pkg;

  localparam int unsigned CHARS_PER_KEY = 7;
  localparam int unsigned TABLE_ROWS    = 10;
  localparam int unsigned TABLE_COLS    = 8;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  CASE_OFFSET   = 8'h20;

  // Key codes.
  localparam logic [7:0] KEY_NONE      = 8'h00;
  localparam logic [7:0] KEY_CASE      = 8'h01;
  localparam logic [7:0] KEY_FN_HOLD   = 8'h02;
  localparam logic [7:0] KEY_FN_BKSP   = 8'h03;
  localparam logic [7:0] KEY_FN_SPACE  = 8'h04;
  localparam logic [7:0] KEY_FN_NL     = 8'h05;
  localparam logic [7:0] KEY_FN_ENTER  = 8'h06;
  localparam logic [7:0] KEY_HASH      = 8'h23;
  localparam logic [7:0] KEY_STAR      = 8'h2A;
  localparam logic [7:0] KEY_DIGIT_LO  = 8'h30;
  localparam logic [7:0] KEY_DIGIT_HI  = 8'h39;
  localparam logic [7:0] KEY_IDLE_LO   = 8'h41;
  localparam logic [7:0] KEY_IDLE_HI   = 8'h44;

  // Characters.
  localparam logic [7:0] CHAR_NONE  = 8'h00;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;

  localparam logic [7:0] KEY_TABLE [TABLE_ROWS][TABLE_COLS] = '{
    '{8'h30, 8'h23, 8'h24, 8'h2E, 8'h3F, 8'h22, 8'h26, 8'h00},
    '{8'h31, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h27, 8'h3A, 8'h00},
    '{8'h41, 8'h42, 8'h43, 8'h32, 8'h21, 8'h3B, 8'h3C, 8'h00},
    '{8'h44, 8'h45, 8'h46, 8'h33, 8'h25, 8'h5B, 8'h3D, 8'h00},
    '{8'h47, 8'h48, 8'h49, 8'h34, 8'h28, 8'h5C, 8'h3E, 8'h00},
    '{8'h4A, 8'h4B, 8'h4C, 8'h35, 8'h29, 8'h5D, 8'h5E, 8'h00},
    '{8'h4D, 8'h4E, 8'h4F, 8'h36, 8'h40, 8'h5F, 8'h60, 8'h00},
    '{8'h50, 8'h51, 8'h52, 8'h53, 8'h37, 8'h7B, 8'h7C, 8'h00},
    '{8'h54, 8'h55, 8'h56, 8'h38, 8'h2C, 8'h7D, 8'h7E, 8'h00},
    '{8'h57, 8'h58, 8'h59, 8'h5A, 8'h39, 8'h20, 8'h00, 8'h00}
  };

  typedef struct packed {
    logic        func;
    logic [7:0]  key_code;
    logic [31:0] now_ms;
  } mtte_item_t;

  typedef struct packed {
    logic        upper_mode;
    logic        pending_valid;
    logic [3:0]  pending_digit;
    logic [2:0]  tap_index;
    logic [31:0] last_tap_time;
  } mtte_state_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       committed;
  } mtte_result_t;

  localparam mtte_state_t STATE_RESET = '{
    upper_mode:    1'b1,
    pending_valid: 1'b0,
    pending_digit: 4'd0,
    tap_index:     3'd0,
    last_tap_time: 32'd0
  };

  function automatic logic [7:0] table_at(logic [3:0] digit, logic [2:0] col);
    logic [7:0] c;
    c = CHAR_NONE;
    if (digit <= 4'(TABLE_ROWS - 1)) begin
      c = KEY_TABLE[digit][col];
    end
    return c;
  endfunction

  function automatic logic [7:0] case_adjust(logic [7:0] c, logic upper);
    logic [7:0] r;
    r = c;
    if (!upper && c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mtte_in_stage.sv =====
// Input register stage: captures one keypad item per transfer and hands it to the step logic.
`timescale 1ns / 1ps
`default_nettype none

module mtte_in_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               func_i,
  input  wire logic [7:0]         key_code_i,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic               take_i,
  output logic                    item_valid_o,
  output mtte_pkg::mtte_item_t    item_o
);
  import mtte_pkg::*;

  logic       valid_q, valid_d;
  mtte_item_t item_q;

  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{func: func_i, key_code: key_code_i, now_ms: now_ms_i};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mtte_step.sv =====
// Step logic: decodes one key item against the entry state and forms the next state and result.
`timescale 1ns / 1ps
`default_nettype none

module mtte_step (
  input  mtte_pkg::mtte_item_t   item_i,
  input  mtte_pkg::mtte_state_t  state_i,
  input  wire logic [15:0]       timeout_i,
  output mtte_pkg::mtte_state_t  state_o,
  output mtte_pkg::mtte_result_t result_o
);
  import mtte_pkg::*;

  logic [7:0]  cur_char;
  logic [31:0] elapsed;
  logic [3:0]  digit;
  logic [3:0]  tap_inc;
  logic [2:0]  tap_next;

  assign cur_char = case_adjust(table_at(state_i.pending_digit, state_i.tap_index),
                                state_i.upper_mode);
  assign elapsed  = item_i.now_ms - state_i.last_tap_time;
  assign digit    = item_i.key_code[3:0];
  assign tap_inc  = {1'b0, state_i.tap_index} + 4'd1;

  always_comb begin
    tap_next = tap_inc[2:0];
    if (tap_inc >= 4'(CHARS_PER_KEY) || table_at(digit, tap_inc[2:0]) == CHAR_NONE) begin
      tap_next = 3'd0;
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '{char_out: CHAR_NONE, committed: 1'b0};
    priority if (item_i.func) begin
      state_o = STATE_RESET;
    end else if (item_i.key_code == KEY_NONE ||
                 (item_i.key_code >= KEY_IDLE_LO && item_i.key_code <= KEY_IDLE_HI)) begin
      if (state_i.pending_valid) begin
        if (elapsed < {16'd0, timeout_i}) begin
          result_o.char_out = cur_char;
        end else begin
          result_o = '{char_out: cur_char, committed: 1'b1};
          state_o.pending_valid = 1'b0;
          state_o.tap_index     = 3'd0;
        end
      end
    end else if (item_i.key_code == KEY_STAR) begin
      state_o.pending_valid = 1'b0;
      state_o.tap_index     = 3'd0;
      state_o.last_tap_time = 32'd0;
    end else if (item_i.key_code < KEY_DIGIT_LO || item_i.key_code > KEY_DIGIT_HI) begin
      priority if (item_i.key_code == KEY_CASE || item_i.key_code == KEY_HASH) begin
        state_o.upper_mode = !state_i.upper_mode;
      end else if (item_i.key_code >= KEY_FN_HOLD && item_i.key_code <= KEY_FN_ENTER) begin
        state_o.tap_index     = 3'd0;
        state_o.last_tap_time = 32'd0;
        if (state_i.pending_valid) begin
          if (item_i.key_code != KEY_FN_HOLD) begin
            result_o = '{char_out: cur_char, committed: 1'b1};
          end
          if (item_i.key_code != KEY_FN_HOLD && item_i.key_code != KEY_FN_SPACE) begin
            state_o.pending_valid = 1'b0;
          end
        end else begin
          priority if (item_i.key_code == KEY_FN_BKSP) begin
            result_o = '{char_out: CHAR_BS, committed: 1'b1};
          end else if (item_i.key_code == KEY_FN_SPACE) begin
            result_o = '{char_out: CHAR_SPACE, committed: 1'b1};
          end else if (item_i.key_code == KEY_FN_NL) begin
            result_o = '{char_out: CHAR_NL, committed: 1'b1};
          end else begin
            result_o = '{char_out: CHAR_NONE, committed: 1'b0};
          end
        end
      end else begin
        state_o = state_i;
      end
    end else begin
      state_o.last_tap_time = item_i.now_ms;
      if (state_i.pending_valid && state_i.pending_digit == digit) begin
        state_o.tap_index = tap_next;
        result_o.char_out = case_adjust(table_at(digit, tap_next), state_i.upper_mode);
      end else begin
        state_o.pending_valid = 1'b1;
        state_o.pending_digit = digit;
        state_o.tap_index     = 3'd0;
        if (state_i.pending_valid) begin
          result_o = '{char_out: cur_char, committed: 1'b1};
        end else begin
          result_o.char_out = case_adjust(table_at(digit, 3'd0), state_i.upper_mode);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/multi_tap_text_entry.sv =====
// Top level of the multi-tap keypad text entry block.
// The block takes one keypad item per clock cycle while results are taken, and gives exactly
// one result item for each. An item is held in an input register, decoded against the entry
// state in one pass of combinational logic, and its result is loaded into the result register
// while the state is updated; the result register's handshake sets the rate. A pending result
// that is not taken stalls the input register, and the input accepts again in the cycle the
// result is taken. The tap timeout register may be written at any time the block is idle and
// takes effect for the next item.
`timescale 1ns / 1ps
`default_nettype none

module multi_tap_text_entry (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        func_i,
  input  wire logic [7:0]  key_code_i,
  input  wire logic [31:0] now_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       char_out_o,
  output logic             committed_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);
  import mtte_pkg::*;

  logic         item_valid;
  mtte_item_t   item;
  logic         advance;
  mtte_state_t  state_q, state_d;
  mtte_result_t result_q, result_d;
  logic         out_valid_q, out_valid_d;
  logic [15:0]  timeout_q;

  assign advance = item_valid && (!out_valid_q || out_ready_i);

  mtte_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .key_code_i   (key_code_i),
    .now_ms_i     (now_ms_i),
    .take_i       (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mtte_step u_step (
    .item_i    (item),
    .state_i   (state_q),
    .timeout_i (timeout_q),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RESET;
      out_valid_q <= 1'b0;
      timeout_q   <= TIMEOUT_RESET;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = result_q.char_out;
  assign committed_o = result_q.committed;

endmodule

`default_nettype wire

// ===== rtl/mtte_checker.sv =====
// Checker: port-level assertions for the multi-tap text entry block, and its binding.
`timescale 1ns / 1ps
`default_nettype none

module mtte_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  char_out_o,
  input wire logic        committed_o
);

  // A result waiting for transfer stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before transfer");

  // With the result register empty, the input register can always drain.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no result pending");

  // Every committed character is a real character.
  a_commit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && committed_o |-> char_out_o != 8'h00)
    else $error("committed an empty character");

  // The table and function keys only produce 7-bit characters.
  a_ascii_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !char_out_o[7])
    else $error("character outside the 7-bit range");

endmodule

bind multi_tap_text_entry mtte_checker u_mtte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .char_out_o  (char_out_o),
  .committed_o (committed_o)
);

`default_nettype wire
